### hdl/sacache_pkg.sv
// shared types and constants for the set-associative cache hit/miss model
package sacache_pkg;

    localparam int NUM_SETS  = 64;
    localparam int NUM_WAYS  = 4;
    localparam int ADDR_W    = 32;
    localparam int TAG_W     = 32;
    localparam int USE_W     = 16;
    localparam int CNT_W     = 32;
    localparam int CYC_W     = 16;
    localparam int SET_W     = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_W     = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int OUT_WAY_W = 2;
    localparam int SIB_W     = 3;
    localparam int OFB_W     = 4;
    localparam int SHIFT_W   = 5;
    localparam int OUT_W     = 104;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    localparam logic [USE_W-1:0] USE_MAX = '1;

    // configuration register indexes
    localparam logic [1:0] REG_SET_INDEX_BITS = 2'd0;
    localparam logic [1:0] REG_OFFSET_BITS    = 2'd1;
    localparam logic [1:0] REG_HIT_CYCLES     = 2'd2;
    localparam logic [1:0] REG_MISS_CYCLES    = 2'd3;

    // reset values of the configuration registers
    localparam logic [SIB_W-1:0] SIB_RESET  = 3'd6;
    localparam logic [OFB_W-1:0] OFB_RESET  = 4'd5;
    localparam logic [CYC_W-1:0] HITC_RESET = 16'd1;
    localparam logic [CYC_W-1:0] MISC_RESET = 16'd100;

    typedef logic [NUM_WAYS-1:0][TAG_W-1:0] tag_row_t;
    typedef logic [NUM_WAYS-1:0][USE_W-1:0] use_row_t;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic read;
        logic commit;
    } sacache_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic slot_free;
    } sacache_status_t;

    // cache geometry and timing settings
    typedef struct packed {
        logic [SIB_W-1:0] set_index_bits;
        logic [OFB_W-1:0] offset_bits;
        logic [CYC_W-1:0] hit_cycles;
        logic [CYC_W-1:0] miss_cycles;
    } sacache_cfg_t;

endpackage

### hdl/sacache_ctrl.sv
// sequencing state machine: accept, row read, lookup and commit
module sacache_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  sacache_pkg::sacache_status_t status,
    output sacache_pkg::sacache_cmd_t    cmd
);
    import sacache_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_CMP  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_READ;
            end
            ST_READ:
                state_next = ST_CMP;
            ST_CMP:
            begin
                if (status.slot_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // commands to the datapath
    always_comb
    begin
        s_tready    = (state_reg == ST_IDLE);
        cmd.capture = (state_reg == ST_IDLE) && s_tvalid;
        cmd.read    = (state_reg == ST_READ);
        cmd.commit  = (state_reg == ST_CMP) && status.slot_free;
    end

endmodule

### hdl/sacache_dp.sv
// datapath: address split, set row memories, lookup, victim choice, counters
module sacache_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sacache_pkg::sacache_cfg_t           cfg,
    input  logic [sacache_pkg::ADDR_W-1:0]      in_address,
    input  sacache_pkg::sacache_cmd_t           cmd,
    output sacache_pkg::sacache_status_t        status,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [sacache_pkg::OUT_W-1:0]       out_data
);
    import sacache_pkg::*;

    logic [ADDR_W-1:0]   addr_reg;
    logic [ADDR_W-1:0]   shifted;
    logic [ADDR_W-1:0]   idx_mask;
    logic [SHIFT_W-1:0]  tag_shift;
    logic [SET_W-1:0]    set_idx;
    logic [TAG_W-1:0]    tag;

    tag_row_t            tag_mem [NUM_SETS];
    use_row_t            use_mem [NUM_SETS];
    tag_row_t            tag_row_reg;
    use_row_t            use_row_reg;
    tag_row_t            tag_row_next;
    use_row_t            use_row_next;
    logic [NUM_WAYS-1:0] valid_reg [NUM_SETS];
    logic [NUM_WAYS-1:0] valid_row;

    use_row_t            use_eff;
    logic                hit;
    logic [WAY_W-1:0]    hit_way;
    logic [WAY_W-1:0]    victim;
    logic [WAY_W-1:0]    chosen;
    logic [USE_W-1:0]    best;
    logic [USE_W-1:0]    new_use;

    logic [CNT_W-1:0]    hit_cnt_reg;
    logic [CNT_W-1:0]    miss_cnt_reg;
    logic [CNT_W-1:0]    cyc_cnt_reg;
    logic [CNT_W-1:0]    hit_cnt_next;
    logic [CNT_W-1:0]    miss_cnt_next;
    logic [CNT_W-1:0]    cyc_cnt_next;

    logic                out_valid_reg;
    logic [OUT_W-1:0]    out_data_reg;

    // address capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            addr_reg <= in_address;
    end

    // split address into set index and tag
    always_comb
    begin
        shifted   = addr_reg >> cfg.offset_bits;
        idx_mask  = (ADDR_W'(1) << cfg.set_index_bits) - ADDR_W'(1);
        set_idx   = SET_W'(shifted & idx_mask);
        tag_shift = SHIFT_W'(cfg.offset_bits) + SHIFT_W'(cfg.set_index_bits);
        tag       = TAG_W'(addr_reg >> tag_shift);
    end

    // set row memories, registered read and full row write
    always_ff @(posedge clk)
    begin
        if (cmd.read)
        begin
            tag_row_reg <= tag_mem[set_idx];
            use_row_reg <= use_mem[set_idx];
        end
        if (cmd.commit)
        begin
            tag_mem[set_idx] <= tag_row_next;
            use_mem[set_idx] <= use_row_next;
        end
    end

    // valid bits per line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_SETS; s++)
                valid_reg[s] <= '0;
        end
        else if (cmd.commit)
        begin
            valid_reg[set_idx][chosen] <= 1'b1;
        end
    end

    // tag match, lowest matching way wins
    always_comb
    begin
        valid_row = valid_reg[set_idx];
        hit       = 1'b0;
        hit_way   = '0;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            if (!hit && valid_row[w] && (tag_row_reg[w] == tag))
            begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
        end
    end

    // least used way, ties go to the highest way; invalid lines count as zero
    always_comb
    begin
        for (int w = 0; w < NUM_WAYS; w++)
            use_eff[w] = valid_row[w] ? use_row_reg[w] : '0;
        best   = use_eff[0];
        victim = '0;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            if (use_eff[w] <= best)
            begin
                best   = use_eff[w];
                victim = WAY_W'(w);
            end
        end
    end

    // row update with saturating use count
    always_comb
    begin
        chosen       = hit ? hit_way : victim;
        new_use      = (use_eff[chosen] == USE_MAX) ? USE_MAX : use_eff[chosen] + USE_W'(1);
        tag_row_next = tag_row_reg;
        use_row_next = use_eff;
        tag_row_next[chosen] = tag;
        use_row_next[chosen] = new_use;
    end

    // running counters
    always_comb
    begin
        hit_cnt_next  = hit_cnt_reg + CNT_W'(hit);
        miss_cnt_next = miss_cnt_reg + CNT_W'(!hit);
        cyc_cnt_next  = cyc_cnt_reg + (hit ? CNT_W'(cfg.hit_cycles) : CNT_W'(cfg.miss_cycles));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
            cyc_cnt_reg  <= '0;
        end
        else if (cmd.commit)
        begin
            hit_cnt_reg  <= hit_cnt_next;
            miss_cnt_reg <= miss_cnt_next;
            cyc_cnt_reg  <= cyc_cnt_next;
        end
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.commit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
            out_data_reg <= {5'b0, cyc_cnt_next, miss_cnt_next, hit_cnt_next,
                             OUT_WAY_W'(chosen), hit};
    end

    assign status.slot_free = !out_valid_reg || out_ready;
    assign out_valid        = out_valid_reg;
    assign out_data         = out_data_reg;

endmodule

### hdl/set_assoc_cache_hit_miss_model.sv
// top level: configuration registers, controller and datapath of the cache model
//
// Usage
//   s_tvalid/s_tready/s_tdata carry one 32-bit access address per word.
//   m_tvalid/m_tready/m_tdata return one result word per address: hit flag,
//   way that hit or was filled, running hit, miss and cycle totals.
//   The APB port sets set index width, offset width, hit and miss cycle
//   costs; write it only while no access is in flight.
// Sequence
//   Each accepted address passes through a capture cycle, a registered
//   read of the set row from the tag and use count memories, and a lookup
//   cycle that writes the row back and registers the result on m_tdata.
//   One address is in flight at a time: the next is taken only once the
//   lookup has committed and the controller is back in idle.
// Stall
//   The result sits in an output register; a new address is accepted while
//   it waits. If it is still not taken when the next result is ready, the
//   lookup holds until m_tready frees the register.
// Reset
//   rst_n clears all valid bits and counters at once (use counts of invalid
//   lines read as zero), and loads the default configuration.
module set_assoc_cache_hit_miss_model (
    input  logic                               clk,
    input  logic                               rst_n,
    // apb configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sacache_pkg::PADDR_W-1:0]    paddr,
    input  logic [sacache_pkg::PDATA_W-1:0]    pwdata,
    output logic [sacache_pkg::PDATA_W-1:0]    prdata,
    output logic                               pready,
    // address stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [31:0]                        s_tdata,  // address[31:0]
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // hit[0], way_used[2:1], hit_count[34:3], miss_count[66:35],
    // cycle_total[98:67], zero pad[103:99]
    output logic [103:0]                       m_tdata
);
    import sacache_pkg::*;

    sacache_cfg_t    cfg_reg;
    sacache_cmd_t    cmd;
    sacache_status_t status;
    logic            wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.set_index_bits <= SIB_RESET;
            cfg_reg.offset_bits    <= OFB_RESET;
            cfg_reg.hit_cycles     <= HITC_RESET;
            cfg_reg.miss_cycles    <= MISC_RESET;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_SET_INDEX_BITS: cfg_reg.set_index_bits <= pwdata[SIB_W-1:0];
                REG_OFFSET_BITS:    cfg_reg.offset_bits    <= pwdata[OFB_W-1:0];
                REG_HIT_CYCLES:     cfg_reg.hit_cycles     <= pwdata[CYC_W-1:0];
                REG_MISS_CYCLES:    cfg_reg.miss_cycles    <= pwdata[CYC_W-1:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        case (paddr[3:2])
            REG_SET_INDEX_BITS: prdata = PDATA_W'(cfg_reg.set_index_bits);
            REG_OFFSET_BITS:    prdata = PDATA_W'(cfg_reg.offset_bits);
            REG_HIT_CYCLES:     prdata = PDATA_W'(cfg_reg.hit_cycles);
            REG_MISS_CYCLES:    prdata = PDATA_W'(cfg_reg.miss_cycles);
            default:            prdata = '0;
        endcase
    end

    sacache_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sacache_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_address (s_tdata),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (m_tdata)
    );

endmodule

### test/tb_set_assoc_cache_hit_miss_model.sv
// testbench for the set-associative cache hit/miss model: address stream in, result words checked
`timescale 1ns / 100ps

module tb_set_assoc_cache_hit_miss_model;
    import sacache_pkg::*;

    localparam int LINES          = NUM_SETS * NUM_WAYS;
    localparam int STALL_LIMIT    = 4000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int PHASE_ITEMS    = 130;
    localparam int SOAK_HITS      = 60;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    // one result word, hit in the lowest bit
    typedef struct packed {
        logic [CNT_W-1:0]     cycle_total;
        logic [CNT_W-1:0]     miss_count;
        logic [CNT_W-1:0]     hit_count;
        logic [OUT_WAY_W-1:0] way_used;
        logic                 hit;
    } access_result_t;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                s_tvalid;
    logic                s_tready;
    logic [31:0]         s_tdata;   // address[31:0]
    logic                m_tvalid;
    logic                m_tready;
    // hit[0], way_used[2:1], hit_count[34:3], miss_count[66:35],
    // cycle_total[98:67], zero pad[103:99]
    logic [103:0]        m_tdata;

    // stimulus and expectations
    logic [ADDR_W-1:0]   addr_queue[$];
    access_result_t      expected_results[$];
    idle_mode_t          idle_mode;
    int                  send_idle_pct;
    int                  recv_stall_pct;
    logic                addr_taken;

    // shadow of the cache contents and settings
    sacache_cfg_t        cache_cfg;
    logic                line_valid_q [LINES];
    logic [TAG_W-1:0]    line_tag_q   [LINES];
    logic [USE_W-1:0]    line_use_q   [LINES];
    logic [CNT_W-1:0]    hits_total;
    logic [CNT_W-1:0]    misses_total;
    logic [CNT_W-1:0]    cycles_total;

    int                  error_count;
    int                  words_checked;
    int                  hits_checked;
    int                  idle_cycles;

    set_assoc_cache_hit_miss_model dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // bump a line's use count, stopping at the top
    function automatic void bump_use(input int line);
        if (line_use_q[line] != USE_MAX)
            line_use_q[line] = line_use_q[line] + 1'b1;
    endfunction

    // look one address up in the shadow cache and return the result word it gives
    function automatic access_result_t lookup_access(input logic [ADDR_W-1:0] addr);
        logic [31:0]      idx_mask;
        logic [SET_W-1:0] set_idx;
        logic [TAG_W-1:0] tag;
        logic [USE_W-1:0] best;
        logic             found;
        int               base;
        int               chosen;
        access_result_t   res;
        idx_mask = (32'd1 << cache_cfg.set_index_bits) - 32'd1;
        // index beyond the set count folds back onto the low bits
        set_idx  = SET_W'((addr >> cache_cfg.offset_bits) & idx_mask);
        tag      = addr >> (int'(cache_cfg.offset_bits) + int'(cache_cfg.set_index_bits));
        base     = int'(set_idx) * NUM_WAYS;
        found    = 1'b0;
        chosen   = 0;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            if (!found && line_valid_q[base + w] && line_tag_q[base + w] == tag)
            begin
                found  = 1'b1;
                chosen = w;
            end
        end
        if (found)
        begin
            hits_total   = hits_total + 1;
            cycles_total = cycles_total + cache_cfg.hit_cycles;
        end
        else
        begin
            misses_total = misses_total + 1;
            cycles_total = cycles_total + cache_cfg.miss_cycles;
            // least used way, ties to the highest
            best = line_use_q[base];
            for (int w = 0; w < NUM_WAYS; w++)
            begin
                if (line_use_q[base + w] <= best)
                begin
                    best   = line_use_q[base + w];
                    chosen = w;
                end
            end
            line_valid_q[base + chosen] = 1'b1;
            line_tag_q[base + chosen]   = tag;
        end
        bump_use(base + chosen);
        res.hit         = found;
        res.way_used    = OUT_WAY_W'(chosen);
        res.hit_count   = hits_total;
        res.miss_count  = misses_total;
        res.cycle_total = cycles_total;
        return res;
    endfunction

    // address driver: holds a word until taken, then offers the next one
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || addr_taken))
        begin
            if (addr_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= addr_queue.pop_front();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver backpressure
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // accepted addresses feed the prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            addr_taken <= 1'b0;
        else
        begin
            addr_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
                expected_results.push_back(lookup_access(s_tdata));
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        access_result_t got;
        access_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[$bits(access_result_t)-1:0];
            words_checked++;
            if (got.hit)
                hits_checked++;
            if (expected_results.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("%0t: result word with no access pending: %h", $realtime, got);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.hit !== want.hit || got.way_used !== want.way_used
                    || got.hit_count !== want.hit_count || got.miss_count !== want.miss_count
                    || got.cycle_total !== want.cycle_total)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display({"%0t: mismatch hit %b/%b way %0d/%0d hits %0d/%0d ",
                                  "misses %0d/%0d cycles %0d/%0d (expected/actual)"},
                                 $realtime, want.hit, got.hit, want.way_used, got.way_used,
                                 want.hit_count, got.hit_count, want.miss_count,
                                 got.miss_count, want.cycle_total, got.cycle_total);
                end
            end
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
            $display("tb_set_assoc_cache_hit_miss_model: done, errors");
            $finish;
        end
    end

    // wait until nothing is pending or in flight, then let the pipeline settle
    task automatic wait_drained();
        do
            @(negedge clk);
        while (addr_queue.size() != 0 || s_tvalid || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // apb write: setup cycle, access cycle
    task automatic apb_write(input logic [1:0] reg_idx, input logic [PDATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (reg_idx)
            REG_SET_INDEX_BITS: cache_cfg.set_index_bits = value[SIB_W-1:0];
            REG_OFFSET_BITS:    cache_cfg.offset_bits    = value[OFB_W-1:0];
            REG_HIT_CYCLES:     cache_cfg.hit_cycles     = value[CYC_W-1:0];
            REG_MISS_CYCLES:    cache_cfg.miss_cycles    = value[CYC_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(input int sib, input int ofb, input int hc, input int mc,
                             input idle_mode_t mode);
        wait_drained();
        apb_write(REG_SET_INDEX_BITS, PDATA_W'(sib));
        apb_write(REG_OFFSET_BITS, PDATA_W'(ofb));
        apb_write(REG_HIT_CYCLES, PDATA_W'(hc));
        apb_write(REG_MISS_CYCLES, PDATA_W'(mc));
        idle_mode      = mode;
        send_idle_pct  = (mode == IDLE_SENDER) ? 65 : (mode == IDLE_BOTH) ? 22 : 0;
        recv_stall_pct = (mode == IDLE_RECEIVER) ? 65 : (mode == IDLE_BOTH) ? 22 : 0;
    endtask

    // random trace: mostly reuse of a small block pool, half of it crowding one set
    task automatic queue_random_trace(input int count);
        logic [ADDR_W-1:0] pool[48];
        logic [31:0]       off_mask;
        logic [31:0]       set_mask;
        logic [ADDR_W-1:0] addr;
        int                pool_size;
        int                roll;
        off_mask  = (32'd1 << cache_cfg.offset_bits) - 32'd1;
        set_mask  = ((32'd1 << cache_cfg.set_index_bits) - 32'd1) << cache_cfg.offset_bits;
        pool_size = $urandom_range(48, 4);
        for (int i = 0; i < pool_size; i++)
        begin
            pool[i] = $urandom & ~off_mask;
            if (i % 2 == 1)
                pool[i] = (pool[i] & ~set_mask) | (pool[0] & set_mask);
        end
        addr = $urandom;
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(99);
            if (roll < 75)
                addr = pool[$urandom_range(pool_size - 1)] | ($urandom & off_mask);
            else if (roll < 90)
                addr = $urandom;
            addr_queue.push_back(addr);
        end
    endtask

    task automatic run_phase(input int sib, input int ofb, input int hc, input int mc,
                             input idle_mode_t mode);
        configure(sib, ofb, hc, mc, mode);
        queue_random_trace(PHASE_ITEMS);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b1;
        idle_mode      = IDLE_NONE;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        error_count    = 0;
        words_checked  = 0;
        hits_checked   = 0;
        idle_cycles    = 0;
        cache_cfg      = '{SIB_RESET, OFB_RESET, HITC_RESET, MISC_RESET};
        hits_total     = '0;
        misses_total   = '0;
        cycles_total   = '0;
        for (int i = 0; i < LINES; i++)
        begin
            line_valid_q[i] = 1'b0;
            line_tag_q[i]   = '0;
            line_use_q[i]   = '0;
        end
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset settings, field extremes, fill and evict one set
        addr_queue = '{32'h0000_0000, 32'h0000_001F, 32'hFFFF_FFFF, 32'hFFFF_FFE0,
                       32'h0000_0800, 32'h0000_1000, 32'h0000_1800, 32'h0000_0800,
                       32'h0000_2000, 32'h0000_1000, 32'hAAAA_AAAA, 32'h5555_5555,
                       32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0000, 32'h7FFF_FFFF,
                       32'h0000_0020, 32'h0000_07E0};

        // random phases through several geometries and idle patterns
        run_phase(0, 0, 0, 0, IDLE_NONE);
        run_phase(7, 15, 16'hFFFF, 16'hFFFF, IDLE_SENDER);
        run_phase(6, 12, $urandom_range(16'hFFFF), $urandom_range(16'hFFFF), IDLE_RECEIVER);
        run_phase(3, 2, $urandom_range(16'hFFFF), $urandom_range(16'hFFFF), IDLE_BOTH);
        run_phase(2, 4, $urandom_range(16'hFFFF), $urandom_range(16'hFFFF), IDLE_NONE);

        // soak one line so its use count towers over the rest, then evict around it
        configure(1, 0, 16'hFFFF, 16'hFFFF, IDLE_NONE);
        for (int i = 0; i < SOAK_HITS; i++)
            addr_queue.push_back(32'h0000_0002);
        addr_queue.push_back(32'h0000_0004);
        addr_queue.push_back(32'h0000_0006);
        addr_queue.push_back(32'h0000_0008);
        addr_queue.push_back(32'h0000_000A);
        addr_queue.push_back(32'h0000_000C);
        addr_queue.push_back(32'h0000_0002);

        run_phase(6, 5, 1, 100, IDLE_SENDER);
        run_phase($urandom_range(7), $urandom_range(15), $urandom_range(16'hFFFF),
                  $urandom_range(16'hFFFF), IDLE_BOTH);
        run_phase($urandom_range(7), $urandom_range(15), $urandom_range(16'hFFFF),
                  $urandom_range(16'hFFFF), IDLE_RECEIVER);
        wait_drained();

        error_count += expected_results.size();
        $display("checked %0d result words (%0d hits) across ten cache settings,", words_checked,
                 hits_checked);
        $display("including a heavily reused line evicted around and all idle patterns");
        if (error_count == 0)
            $display("tb_set_assoc_cache_hit_miss_model: done, clean");
        else
            $display("tb_set_assoc_cache_hit_miss_model: done, errors");
        $finish;
    end

endmodule
